### src/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher.
// Holds the payload structs, the sequencer state type and the register map.
// Has no dependencies.
package rc4_pkg;

	localparam int MAX_KEY_BYTES = 16;
	localparam int TABLE_DEPTH   = 256;
	localparam int ADDR_W        = $clog2(TABLE_DEPTH);
	localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
	localparam int KEY_LEN_W     = 5;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;

	localparam logic [CFG_DATA_W-1:0] KEY_LOW_RESET  = 64'h0000_0000_0603_0201;
	localparam logic [CFG_DATA_W-1:0] KEY_HIGH_RESET = 64'h0;
	localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET  = 5'd4;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_LOW  = 2'd0,
		CFG_KEY_HIGH = 2'd1,
		CFG_KEY_LEN  = 2'd2
	} cfg_reg_t;

	// Input transaction payload.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_message;
	} rc4_in_t;

	// Output transaction payload.
	typedef struct packed {
		logic [7:0] cipher_byte;
		logic [7:0] keystream_byte;
	} rc4_out_t;

	// Sequencer states: table fill, key schedule and generation steps.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_KRD_N,
		ST_KRD_J,
		ST_KWR_N,
		ST_KWR_J,
		ST_PRD_I,
		ST_PRD_J,
		ST_PWR_I,
		ST_PWR_J
	} rc4_state_t;

	// Clamp the programmed key length to the range 1 to MAX_KEY_BYTES.
	function automatic logic [KEY_LEN_W-1:0] key_len_eff(input logic [KEY_LEN_W-1:0] len);
		logic [KEY_LEN_W-1:0] res;
		if (len == '0) begin
			res = KEY_LEN_W'(1);
		end else if (len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
			res = KEY_LEN_W'(MAX_KEY_BYTES);
		end else begin
			res = len;
		end
		return res;
	endfunction

endpackage

### src/rc4_stream_cipher.sv
// RC4 stream cipher top level: permutation memory, sequencer and channel logic.
// Depends on rc4_pkg for payload structs, state type and constants.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    rc4_in_t  (data_byte, start_of_message)
// out       output     out_valid / out_stall  rc4_out_t (cipher_byte, keystream_byte)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data (64 bits)
//
// Each byte is accepted in the idle state and then takes four steps through the
// permutation memory, which has a write and a read port (read i, read j, swap and
// read the keystream entry, final write). A start of message, and the first byte
// after reset, first runs an identity fill of all 256 entries and a key schedule
// (four memory accesses per entry). Reset clears control state and restores the
// key registers; the table is rebuilt before first use. A stalled output holds the
// sequencer in its last step, while the input is stalled until the sequencer idles.
module rc4_stream_cipher (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  rc4_pkg::rc4_in_t            in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output rc4_pkg::rc4_out_t           out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rc4_pkg::*;

	rc4_state_t state_q, state_nx;

	logic [CFG_DATA_W-1:0] key_lo_q, key_hi_q;
	logic [KEY_LEN_W-1:0]  key_len_q;
	logic [2*CFG_DATA_W-1:0] key_all;

	logic [7:0]           perm_mem [TABLE_DEPTH];
	logic [7:0]           rdata_q;
	logic                 mem_we, mem_re;
	logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
	logic [7:0]           mem_wdata;

	logic [ADDR_W-1:0]    cnt_q, acc_q, i_q, j_q, t_q;
	logic [KEY_IDX_W-1:0] kidx_q;
	logic [7:0]           held_q, si_q, sj_q, data_q;
	logic                 need_q;

	logic                 out_valid_q;
	rc4_out_t             out_q;

	logic                 in_accept, out_free, cnt_last, kidx_wrap;
	logic [KEY_LEN_W-1:0] len_eff;
	logic [7:0]           key_byte, ks;
	logic [ADDR_W-1:0]    acc_nx, i_nx, j_nx, t_nx;

	// Handshake terms.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// Key byte selection and schedule arithmetic.
	assign len_eff   = key_len_eff(key_len_q);
	assign kidx_wrap = ({1'b0, kidx_q} == (len_eff - KEY_LEN_W'(1)));
	assign key_all   = {key_hi_q, key_lo_q};
	assign key_byte  = key_all[kidx_q*8 +: 8];
	assign cnt_last  = (cnt_q == ADDR_W'(TABLE_DEPTH - 1));
	assign acc_nx    = acc_q + rdata_q + key_byte;
	assign i_nx      = i_q + ADDR_W'(1);
	assign j_nx      = j_q + rdata_q;
	assign t_nx      = si_q + rdata_q;

	// The keystream entry was read while S[i] was being written and before S[j]
	// was written, so the swapped values are forwarded here.
	always_comb begin
		if (t_q == j_q) begin
			ks = si_q;
		end else if (t_q == i_q) begin
			ks = sj_q;
		end else begin
			ks = rdata_q;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= KEY_LOW_RESET;
			key_hi_q  <= KEY_HIGH_RESET;
			key_len_q <= KEY_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY_LOW:  key_lo_q  <= cfg_data;
				CFG_KEY_HIGH: key_hi_q  <= cfg_data;
				CFG_KEY_LEN:  key_len_q <= cfg_data[KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_nx = (in_data.start_of_message || need_q) ? ST_FILL : ST_PRD_I;
				end
			end
			ST_FILL:  state_nx = cnt_last ? ST_KRD_N : ST_FILL;
			ST_KRD_N: state_nx = ST_KRD_J;
			ST_KRD_J: state_nx = ST_KWR_N;
			ST_KWR_N: state_nx = ST_KWR_J;
			ST_KWR_J: state_nx = cnt_last ? ST_PRD_I : ST_KRD_N;
			ST_PRD_I: state_nx = ST_PRD_J;
			ST_PRD_J: state_nx = ST_PWR_I;
			ST_PWR_I: state_nx = ST_PWR_J;
			ST_PWR_J: state_nx = out_free ? ST_IDLE : ST_PWR_J;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = cnt_q;
		mem_re    = 1'b0;
		mem_raddr = cnt_q;
		unique case (state_q)
			ST_IDLE: ;
			ST_FILL: begin
				mem_we = 1'b1;
			end
			ST_KRD_N: begin
				mem_re = 1'b1;
			end
			ST_KRD_J: begin
				mem_re    = 1'b1;
				mem_raddr = acc_nx;
			end
			ST_KWR_N: begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q;
			end
			ST_KWR_J: begin
				mem_we    = 1'b1;
				mem_waddr = acc_q;
				mem_wdata = held_q;
			end
			ST_PRD_I: begin
				mem_re    = 1'b1;
				mem_raddr = i_nx;
			end
			ST_PRD_J: begin
				mem_re    = 1'b1;
				mem_raddr = j_nx;
			end
			ST_PWR_I: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = rdata_q;
				mem_re    = 1'b1;
				mem_raddr = t_nx;
			end
			ST_PWR_J: begin
				mem_we    = out_free;
				mem_waddr = j_q;
				mem_wdata = si_q;
			end
			default: ;
		endcase
	end

	// Permutation memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			perm_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= perm_mem[mem_raddr];
		end
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			need_q  <= 1'b1;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_FILL) begin
				need_q <= 1'b0;
			end
		end
	end

	// Sequencer datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					data_q <= in_data.data_byte;
					cnt_q  <= '0;
				end
			end
			ST_FILL: begin
				cnt_q  <= cnt_q + ADDR_W'(1);
				acc_q  <= '0;
				kidx_q <= '0;
			end
			ST_KRD_J: begin
				held_q <= rdata_q;
				acc_q  <= acc_nx;
			end
			ST_KWR_J: begin
				cnt_q  <= cnt_q + ADDR_W'(1);
				kidx_q <= kidx_wrap ? '0 : kidx_q + KEY_IDX_W'(1);
				if (cnt_last) begin
					i_q <= '0;
					j_q <= '0;
				end
			end
			ST_PRD_I: begin
				i_q <= i_nx;
			end
			ST_PRD_J: begin
				si_q <= rdata_q;
				j_q  <= j_nx;
			end
			ST_PWR_I: begin
				sj_q <= rdata_q;
				t_q  <= t_nx;
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PWR_J && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PWR_J && out_free) begin
			out_q.cipher_byte    <= data_q ^ ks;
			out_q.keystream_byte <= ks;
		end
	end

	// A new result only appears after the final generation step.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_PWR_J))
		else $error("result appeared outside the final generation step");

	// A start of message always rebuilds the table.
	a_start_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_data.start_of_message) |=> (state_q == ST_FILL))
		else $error("start of message did not begin the table fill");

	// No result is delivered while the table still awaits its first fill.
	a_schedule_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !need_q)
		else $error("result delivered before any key schedule");

	// The generation steps are entered only once the first table fill has begun.
	a_gen_after_sched: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRD_I) |-> !need_q)
		else $error("generation step started without a key schedule");

endmodule
